FILE: rtl/windowed_moving_average_assert.svh
// Assertion macros for the windowed moving average block.
// Used by windowed_moving_average.sv; no other dependencies.
`ifndef WINDOWED_MOVING_AVERAGE_ASSERT_SVH
`define WINDOWED_MOVING_AVERAGE_ASSERT_SVH
`ifndef SYNTHESIS
`define WMA_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wma: same-cycle check failed");
`define WMA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wma: next-cycle check failed");
`else
`define WMA_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define WMA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/wma_pkg.sv
// Shared constants for the windowed moving average block.
// Used by the stream interfaces and the top level; no dependencies.
package wma_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int SAMPLE_BITS_DEF  = 16;

  localparam int               CFG_W          = 7;
  localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 7'd8;

endpackage

FILE: rtl/wma_if.sv
// Valid/ready stream interfaces for samples in and averages out.
// Depends on wma_pkg for the default sample width.
interface wma_sample_if #(
  parameter int SAMPLE_BITS = wma_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wma_average_if #(
  parameter int SAMPLE_BITS = wma_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

FILE: rtl/windowed_moving_average.sv
// Windowed moving average: sample ring, running sum and serial divider.
// Depends on wma_pkg, wma_if.sv and windowed_moving_average_assert.svh.
//
//  channel     dir   payload               transfer when
//  sample_ch   in    sample  [SB-1:0]      valid & ready
//  average_ch  out   average [SB-1:0]      valid & ready
//  wr_en/data  in    window_len [6:0]      wr_en high
//
// The block takes no new sample until the last one has been loaded into the
// output register; the restoring divider retires one quotient bit per cycle.
// Synchronous reset clears the ring through per-entry fill bits, so no
// clearing pass is needed. A stalled average waits in the output register;
// a finished quotient waits for it to drain before the block goes ready.
module windowed_moving_average #(
  parameter int WINDOW_DEPTH = wma_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_BITS  = wma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  wma_sample_if.sink                 sample_ch,
  wma_average_if.source              average_ch,
  input  logic                       wr_en,
  input  logic [wma_pkg::CFG_W-1:0]  wr_data
);

  localparam int PTR_W  = $clog2(WINDOW_DEPTH);
  localparam int DEP_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int LEN_W  = (DEP_W > wma_pkg::CFG_W) ? DEP_W : wma_pkg::CFG_W;
  localparam int SUM_W  = SAMPLE_BITS + PTR_W + 1;
  localparam int CNT_W  = $clog2(SUM_W);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_UPDATE = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam logic [SUM_W-1:0] MAX_MAG =
    {{(SUM_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SUM_W-1:0] MIN_MAG = MAX_MAG + SUM_W'(1);

  logic [2:0]                    state;
  logic [wma_pkg::CFG_W-1:0]     window_len;
  logic [LEN_W-1:0]              len_eff;
  logic [LEN_W-1:0]              len_reg;
  logic [PTR_W-1:0]              pos;
  logic [LEN_W-1:0]              pos_ext;
  logic [LEN_W-1:0]              pos_inc;
  logic signed [SAMPLE_BITS-1:0] sample_reg;
  logic signed [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic [WINDOW_DEPTH-1:0]       filled;
  logic signed [SUM_W-1:0]       sum;
  logic signed [SUM_W-1:0]       sum_next;
  logic [SUM_W-1:0]              dq;
  logic [LEN_W-1:0]              rem;
  logic [LEN_W:0]                rem_sh;
  logic                          q_bit;
  logic                          div_neg;
  logic [CNT_W-1:0]              cnt;
  logic                          out_valid;
  logic                          out_load;
  logic signed [SAMPLE_BITS-1:0] average_reg;
  logic signed [SAMPLE_BITS-1:0] average_next;
  logic                          in_xfer;
  logic                          mem_we;

  assign sample_ch.ready    = (state == S_IDLE);
  assign in_xfer            = sample_ch.valid && sample_ch.ready;
  assign average_ch.valid   = out_valid;
  assign average_ch.average = average_reg;
  assign mem_we             = (state == S_UPDATE);
  assign out_load           = (state == S_FINISH) && (!out_valid || average_ch.ready);

  always_comb begin
    if (window_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (LEN_W'(window_len) > LEN_W'(WINDOW_DEPTH)) begin
      len_eff = LEN_W'(WINDOW_DEPTH);
    end else begin
      len_eff = LEN_W'(window_len);
    end
  end

  assign pos_ext    = LEN_W'(pos);
  assign pos_inc    = pos_ext + LEN_W'(1);
  assign old_sample = filled[pos] ? rd_data : '0;
  assign sum_next   = sum - SUM_W'(old_sample) + SUM_W'(sample_reg);
  assign rem_sh     = {rem, dq[SUM_W-1]};
  assign q_bit      = (rem_sh >= {1'b0, len_reg});

  always_comb begin
    if (!div_neg) begin
      average_next = (dq > MAX_MAG) ? SAMPLE_BITS'(MAX_MAG) : SAMPLE_BITS'(dq);
    end else if (dq > MIN_MAG) begin
      average_next = SAMPLE_BITS'(MIN_MAG);
    end else begin
      average_next = SAMPLE_BITS'(-dq);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos] <= sample_reg;
    end
    rd_data <= mem[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= wma_pkg::WINDOW_LEN_RST;
    end else if (wr_en) begin
      window_len <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      filled    <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (average_ch.valid && average_ch.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            sample_reg <= sample_ch.sample;
            len_reg    <= len_eff;
            if (pos_ext >= len_eff) begin
              pos <= '0;
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          sum         <= sum_next;
          filled[pos] <= 1'b1;
          pos         <= (pos_inc >= len_reg) ? '0 : PTR_W'(pos_inc);
          div_neg     <= sum_next[SUM_W-1];
          dq          <= sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
          rem         <= '0;
          cnt         <= '0;
          state       <= S_DIV;
        end
        S_DIV: begin
          rem <= q_bit ? LEN_W'(rem_sh - {1'b0, len_reg}) : LEN_W'(rem_sh);
          dq  <= {dq[SUM_W-2:0], q_bit};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(SUM_W - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            average_reg <= average_next;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "windowed_moving_average_assert.svh"

  `WMA_ASSERT_NEXT(a_busy_after_xfer, clk, rst, in_xfer, !sample_ch.ready)
  `WMA_ASSERT_IMPLIES(a_pos_in_window, clk, rst, state == S_DIV, pos_ext < len_reg)
  `WMA_ASSERT_NEXT(a_result_loaded, clk, rst, out_load, out_valid && state == S_IDLE)

endmodule

FILE: tb/sv/windowed_moving_average_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for windowed_moving_average: directed table, then random phases.
// Depends on wma_pkg, wma_if.sv and the windowed_moving_average RTL.
module windowed_moving_average_tb;

  localparam int DEPTH = wma_pkg::WINDOW_DEPTH_DEF;
  localparam int SB = wma_pkg::SAMPLE_BITS_DEF;
  localparam int CFG_W = wma_pkg::CFG_W;
  localparam longint AVG_MAX = (longint'(1) <<< (SB - 1)) - 1;
  localparam longint AVG_MIN = -AVG_MAX - 1;
  localparam int RANDOM_ITEMS = 550;
  localparam int SETTLE_CYCLES = 32;
  localparam int DRAIN_CYCLES = 40;
  localparam longint TIMEOUT_NS = 5_000_000;

  typedef enum logic {ROW_SAMPLE, ROW_LENGTH} row_kind_t;
  typedef enum logic [1:0] {MIX_UNIFORM, MIX_HIGH, MIX_LOW, MIX_NEAR_ZERO} sample_mix_t;

  typedef struct {
    row_kind_t kind;
    logic [SB-1:0] value;
    bit typed;
    logic [SB-1:0] avg;
  } row_t;

  typedef struct {
    logic [CFG_W-1:0] len;
    sample_mix_t mix;
  } phase_t;

  row_t directed_rows [24] = '{
    '{ROW_SAMPLE, 16'h0000, 1'b1, 16'h0000},
    '{ROW_SAMPLE, 16'h7FFF, 1'b1, 16'h0FFF},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h0000},
    '{ROW_SAMPLE, 16'hFFFF, 1'b1, 16'h0000},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 16'hF000},
    '{ROW_LENGTH, 16'd0,    1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h1234, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h8000, 1'b0, 16'h0000},
    '{ROW_LENGTH, 16'd127,  1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_LENGTH, 16'd64,   1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_LENGTH, 16'd2,    1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_LENGTH, 16'd1,    1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_LENGTH, 16'd8,    1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h5555, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'hAAAA, 1'b0, 16'h0000}
  };

  phase_t opening_phases [6] = '{
    '{7'd64,  MIX_LOW},
    '{7'd1,   MIX_LOW},
    '{7'd127, MIX_HIGH},
    '{7'd0,   MIX_HIGH},
    '{7'd65,  MIX_UNIFORM},
    '{7'd63,  MIX_NEAR_ZERO}
  };

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [CFG_W-1:0] wr_data;

  wma_sample_if sample_ch ();
  wma_average_if average_ch ();

  windowed_moving_average dut (
    .clk        (clk),
    .rst        (rst),
    .sample_ch  (sample_ch),
    .average_ch (average_ch),
    .wr_en      (wr_en),
    .wr_data    (wr_data)
  );

  logic signed [SB-1:0] window_mirror [DEPTH] = '{default: '0};
  longint window_sum = 0;
  int unsigned write_pos = 0;
  logic [CFG_W-1:0] len_reg = wma_pkg::WINDOW_LEN_RST;

  logic [SB-1:0] avg_expected [$];
  logic [SB-1:0] want;
  int mismatches = 0;
  int burst_left = 0;
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [7:0] stall_tick = '0;

  int sent;
  int phase;
  int phase_items;
  logic [CFG_W-1:0] phase_len;
  sample_mix_t phase_mix;

  always #5 clk = ~clk;

  function automatic logic [SB-1:0] advance_window(input logic signed [SB-1:0] s);
    int unsigned n;
    longint q;
    n = (len_reg == 0) ? 1 : (len_reg > DEPTH) ? DEPTH : len_reg;
    if (write_pos >= n) write_pos = 0;
    window_sum = window_sum - longint'(window_mirror[write_pos]) + longint'(s);
    window_mirror[write_pos] = s;
    write_pos = (write_pos + 1 >= n) ? 0 : write_pos + 1;
    q = window_sum / longint'(n);
    if (q > AVG_MAX) q = AVG_MAX;
    if (q < AVG_MIN) q = AVG_MIN;
    return q[SB-1:0];
  endfunction

  function automatic logic [SB-1:0] pick_sample(input sample_mix_t mix);
    case (mix)
      MIX_HIGH: return ($urandom_range(0, 3) != 0) ? 16'h7FFF : 16'($urandom);
      MIX_LOW: return ($urandom_range(0, 3) != 0) ? 16'h8000 : 16'($urandom);
      MIX_NEAR_ZERO: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void flag_mismatch(input string what, input logic [SB-1:0] exp_v,
                                        input logic [SB-1:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected %0d got %0d", $time, what, $signed(exp_v), $signed(got_v));
  endfunction

  task automatic send_sample(input logic [SB-1:0] s, input bit typed,
                             input logic [SB-1:0] avg);
    int gap;
    logic [SB-1:0] predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.sample <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    predicted = advance_window(s);
    avg_expected.push_back(typed ? avg : predicted);
    burst_left--;
  endtask

  task automatic write_length(input logic [CFG_W-1:0] v);
    sample_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (avg_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    wr_en <= 1'b1;
    wr_data <= v;
    @(posedge clk);
    wr_en <= 1'b0;
    len_reg = v;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      average_ch.ready <= 1'b0;
    end else begin
      if (average_ch.valid && average_ch.ready) begin
        if (avg_expected.size() == 0) begin
          flag_mismatch("unexpected average", 'x, average_ch.average);
        end else begin
          want = avg_expected.pop_front();
          if (average_ch.average !== want) flag_mismatch("average", want, average_ch.average);
        end
      end
      stall_tick <= stall_tick + 1'b1;
      if (stall_tick == 8'hFF)
        stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      average_ch.ready <= stall_pattern[stall_tick[3:0]];
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("windowed_moving_average regression: fail");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_data <= '0;
    sample_ch.valid <= 1'b0;
    sample_ch.sample <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_LENGTH)
        write_length(directed_rows[i].value[CFG_W-1:0]);
      else
        send_sample(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].avg);
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase < $size(opening_phases)) begin
        phase_len = opening_phases[phase].len;
        phase_mix = opening_phases[phase].mix;
      end else begin
        phase_len = CFG_W'($urandom_range(0, 127));
        phase_mix = sample_mix_t'($urandom_range(0, 3));
      end
      write_length(phase_len);
      phase_items = $urandom_range(10, 60);
      repeat (phase_items) begin
        send_sample(pick_sample(phase_mix), 1'b0, '0);
        sent++;
      end
      phase++;
    end

    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (avg_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("windowed_moving_average regression: pass");
    else
      $display("windowed_moving_average regression: fail");
    $finish;
  end
endmodule
